[design/ah2c_pkg.sv]
package ah2c_pkg;

    // configuration register indexes
    localparam logic [7:0] REG_SEPARATOR  = 8'd0;
    localparam logic [7:0] REG_TERMINATOR = 8'd1;

    // configuration reset values: comma and line feed
    localparam logic [7:0] SEPARATOR_RESET  = 8'd44;
    localparam logic [7:0] TERMINATOR_RESET = 8'd10;

    // data byte slots in one frame
    localparam int PAYLOAD_SLOTS = 8;
    localparam int SLOT_IDX_W    = 3;
    localparam int COUNT_W       = 4;

    // field of the line being parsed
    typedef enum logic [1:0] {
        FIELD_ID   = 2'd0,
        FIELD_RTR  = 2'd1,
        FIELD_IDE  = 2'd2,
        FIELD_DATA = 2'd3
    } field_pos_t;

    // one parsed frame, first member in the top bits
    typedef struct packed {
        logic                         data_truncated;
        logic [8*PAYLOAD_SLOTS-1:0]   data_bytes;
        logic [COUNT_W-1:0]           data_length;
        logic [7:0]                   extended_value;
        logic [7:0]                   remote_value;
        logic [31:0]                  frame_id;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);
    localparam int TDATA_W = ((FRAME_W + 7) / 8) * 8;

    // ascii hex digit to nibble, anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
            end
            return d[3:0];
        end
    endfunction

endpackage

[design/ah2c_parse.sv]
module ah2c_parse
    import ah2c_pkg::*;
#(
    parameter int LINE_BUFFER_LEN = 64,
    parameter int MAX_PAYLOAD     = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_in,
    input  logic       char_fire,
    input  logic [7:0] separator_char,
    input  logic [7:0] terminator_char,
    output logic       frame_valid,
    output frame_t     frame
);

    localparam int              CHAR_W     = $clog2(LINE_BUFFER_LEN + 1);
    localparam logic [CHAR_W-1:0] LINE_LIMIT = CHAR_W'(LINE_BUFFER_LEN);
    localparam logic [COUNT_W-1:0] MAX_CNT   = COUNT_W'(MAX_PAYLOAD);

    field_pos_t           field_reg, field_next;
    logic                 phase_reg, phase_next;
    logic [3:0]           upper_reg, upper_next;
    logic [31:0]          id_reg, id_next;
    logic [7:0]           remote_reg, remote_next;
    logic [7:0]           extended_reg, extended_next;
    logic                 taken_reg, taken_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 overflow_reg, overflow_next;
    logic                 closed_reg, closed_next;
    logic [CHAR_W-1:0]    chars_reg, chars_next;
    logic [7:0]           payload_reg [PAYLOAD_SLOTS];

    // state as seen after a possible long-line restart
    logic                 restart;
    field_pos_t           field_eff;
    logic                 phase_eff;
    logic [3:0]           upper_eff;
    logic [31:0]          id_eff;
    logic [7:0]           remote_eff;
    logic [7:0]           extended_eff;
    logic                 taken_eff;
    logic [COUNT_W-1:0]   count_eff;
    logic                 overflow_eff;
    logic                 closed_eff;
    logic [CHAR_W-1:0]    chars_eff;

    // byte commit
    logic                 is_term;
    logic                 is_sep;
    logic                 commit;
    logic [7:0]           commit_byte;
    logic [31:0]          id_c;
    logic [7:0]           remote_c;
    logic [7:0]           extended_c;
    logic                 taken_c;
    logic [COUNT_W-1:0]   count_c;
    logic                 overflow_c;
    logic                 store_we;

    // restart view of the state
    always_comb
    begin
        restart      = (chars_reg >= LINE_LIMIT);
        field_eff    = restart ? FIELD_ID : field_reg;
        phase_eff    = restart ? 1'b0 : phase_reg;
        upper_eff    = restart ? 4'd0 : upper_reg;
        id_eff       = restart ? 32'd0 : id_reg;
        remote_eff   = restart ? 8'd0 : remote_reg;
        extended_eff = restart ? 8'd0 : extended_reg;
        taken_eff    = restart ? 1'b0 : taken_reg;
        count_eff    = restart ? '0 : count_reg;
        overflow_eff = restart ? 1'b0 : overflow_reg;
        closed_eff   = restart ? 1'b0 : closed_reg;
        chars_eff    = restart ? '0 : chars_reg;
    end

    // byte formed from the pending nibble and this character
    always_comb
    begin
        is_term     = (char_in == terminator_char);
        is_sep      = !is_term && (char_in == separator_char);
        commit      = phase_eff && !closed_eff;
        commit_byte = (is_term || is_sep) ? {upper_eff, 4'h0}
                                          : {upper_eff, hex_nibble(char_in)};

        id_c       = id_eff;
        remote_c   = remote_eff;
        extended_c = extended_eff;
        taken_c    = taken_eff;
        count_c    = count_eff;
        overflow_c = overflow_eff;
        store_we   = 1'b0;
        if (commit)
        begin
            unique case (field_eff)
                FIELD_ID:
                begin
                    id_c = {id_eff[23:0], commit_byte};
                end
                FIELD_RTR:
                begin
                    if (!taken_eff)
                    begin
                        remote_c = commit_byte;
                        taken_c  = 1'b1;
                    end
                end
                FIELD_IDE:
                begin
                    if (!taken_eff)
                    begin
                        extended_c = commit_byte;
                        taken_c    = 1'b1;
                    end
                end
                FIELD_DATA:
                begin
                    if (count_eff < MAX_CNT)
                    begin
                        store_we = 1'b1;
                        count_c  = count_eff + 1'b1;
                    end
                    else
                    begin
                        overflow_c = 1'b1;
                    end
                end
                default:
                begin
                    id_c = id_eff;
                end
            endcase
        end
    end

    // next state of the line parser
    always_comb
    begin
        field_next    = field_reg;
        phase_next    = phase_reg;
        upper_next    = upper_reg;
        id_next       = id_reg;
        remote_next   = remote_reg;
        extended_next = extended_reg;
        taken_next    = taken_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        closed_next   = closed_reg;
        chars_next    = chars_reg;
        if (char_fire)
        begin
            // defaults: restart applied, character counted
            field_next    = field_eff;
            phase_next    = phase_eff;
            upper_next    = upper_eff;
            id_next       = id_eff;
            remote_next   = remote_eff;
            extended_next = extended_eff;
            taken_next    = taken_eff;
            count_next    = count_eff;
            overflow_next = overflow_eff;
            closed_next   = closed_eff;
            chars_next    = chars_eff + 1'b1;
            if (is_term)
            begin
                field_next    = FIELD_ID;
                phase_next    = 1'b0;
                upper_next    = 4'd0;
                id_next       = 32'd0;
                remote_next   = 8'd0;
                extended_next = 8'd0;
                taken_next    = 1'b0;
                count_next    = '0;
                overflow_next = 1'b0;
                closed_next   = 1'b0;
                chars_next    = '0;
            end
            else if (!closed_eff)
            begin
                id_next       = id_c;
                remote_next   = remote_c;
                extended_next = extended_c;
                taken_next    = taken_c;
                count_next    = count_c;
                overflow_next = overflow_c;
                if (is_sep)
                begin
                    phase_next = 1'b0;
                    upper_next = 4'd0;
                    unique case (field_eff)
                        FIELD_ID:
                        begin
                            field_next = FIELD_RTR;
                            taken_next = 1'b0;
                        end
                        FIELD_RTR:
                        begin
                            field_next = FIELD_IDE;
                            taken_next = 1'b0;
                        end
                        FIELD_IDE:
                        begin
                            field_next = FIELD_DATA;
                            taken_next = 1'b0;
                        end
                        FIELD_DATA:
                        begin
                            closed_next = 1'b1;
                        end
                        default:
                        begin
                            closed_next = 1'b1;
                        end
                    endcase
                end
                else if (!phase_eff)
                begin
                    upper_next = hex_nibble(char_in);
                    phase_next = 1'b1;
                end
                else
                begin
                    upper_next = 4'd0;
                    phase_next = 1'b0;
                end
            end
        end
    end

    // frame assembled at the terminator
    always_comb
    begin
        frame_valid          = char_fire && is_term;
        frame.frame_id       = id_c;
        frame.remote_value   = remote_c;
        frame.extended_value = extended_c;
        frame.data_length    = count_c;
        frame.data_truncated = overflow_c;
        for (int k = 0; k < PAYLOAD_SLOTS; k++)
        begin
            if (COUNT_W'(k) >= count_c)
            begin
                frame.data_bytes[8*k +: 8] = 8'd0;
            end
            else if (store_we && (count_eff[SLOT_IDX_W-1:0] == SLOT_IDX_W'(k)))
            begin
                frame.data_bytes[8*k +: 8] = commit_byte;
            end
            else
            begin
                frame.data_bytes[8*k +: 8] = payload_reg[k];
            end
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg    <= FIELD_ID;
            phase_reg    <= 1'b0;
            upper_reg    <= 4'd0;
            id_reg       <= 32'd0;
            remote_reg   <= 8'd0;
            extended_reg <= 8'd0;
            taken_reg    <= 1'b0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            closed_reg   <= 1'b0;
            chars_reg    <= '0;
        end
        else
        begin
            field_reg    <= field_next;
            phase_reg    <= phase_next;
            upper_reg    <= upper_next;
            id_reg       <= id_next;
            remote_reg   <= remote_next;
            extended_reg <= extended_next;
            taken_reg    <= taken_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            closed_reg   <= closed_next;
            chars_reg    <= chars_next;
        end
    end

    // data byte slots, masked by the count on read
    always_ff @(posedge clk)
    begin
        if (char_fire && store_we)
        begin
            payload_reg[count_eff[SLOT_IDX_W-1:0]] <= commit_byte;
        end
    end

endmodule

[design/ascii_hex_line_to_can_frame_core.sv]
// ascii hex line to can frame parser
//
// s_* channel: one character per item in s_tdata[7:0]. characters build a line
// of four fields (id, rtr, ide, data) in hex, split by the separator and closed
// by the terminator. each terminator yields one frame item on the m_* channel.
// cfg_* channel: register writes, index 0 separator, index 1 terminator; other
// indexes are ignored. cfg_ready is always high; write only while idle.
//
// throughput: one character per cycle while s_tready is high. the parse state
// updates in the cycle the character is taken, and the frame is registered at
// that edge into the frame register, or into the skid register while stalled.
// the output has a frame register plus one skid register: while the receiver
// stalls, characters keep being taken until a second frame is waiting, then
// s_tready drops until the receiver takes a frame.
// reset: separator 44, terminator 10, parser at the start of a line, no frames
// pending. a line longer than LINE_BUFFER_LEN characters restarts the parse.
module ascii_hex_line_to_can_frame_core
    import ah2c_pkg::*;
#(
    parameter int LINE_BUFFER_LEN = 64,
    parameter int MAX_PAYLOAD     = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // char_in
    output logic               m_tvalid,
    input  logic               m_tready,
    // frame_id, remote_value, extended_value, data_length, data_bytes,
    // data_truncated, zero pad
    output logic [TDATA_W-1:0] m_tdata,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    logic [7:0] separator_reg;
    logic [7:0] terminator_reg;

    logic       in_fire;
    logic       out_fire;
    logic       frame_valid;
    frame_t     frame;

    frame_t     out_reg;
    logic       out_valid_reg;
    frame_t     skid_reg;
    logic       skid_valid_reg;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign out_fire  = out_valid_reg && m_tready;
    assign m_tdata   = {{(TDATA_W - FRAME_W){1'b0}}, out_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg  <= SEPARATOR_RESET;
            terminator_reg <= TERMINATOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SEPARATOR:  separator_reg  <= cfg_data;
                REG_TERMINATOR: terminator_reg <= cfg_data;
                default:        separator_reg  <= separator_reg;
            endcase
        end
    end

    // line parser
    ah2c_parse #(
        .LINE_BUFFER_LEN (LINE_BUFFER_LEN),
        .MAX_PAYLOAD     (MAX_PAYLOAD)
    ) u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_in         (s_tdata),
        .char_fire       (in_fire),
        .separator_char  (separator_reg),
        .terminator_char (terminator_reg),
        .frame_valid     (frame_valid),
        .frame           (frame)
    );

    // output register and skid register, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= frame_valid;
            end
        end
        else if (frame_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid register, payload
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_reg <= skid_valid_reg ? skid_reg : frame;
        end
        else if (frame_valid)
        begin
            skid_reg <= frame;
        end
    end

    // a waiting skid frame always has a frame ahead of it
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid frame without output frame");

    // a frame never reports more bytes than the limit
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.data_length <= COUNT_W'(MAX_PAYLOAD)))
        else $error("data length above limit");

    // truncation only once the byte slots are full
    a_truncated_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_reg.data_truncated)
            |-> (out_reg.data_length == COUNT_W'(MAX_PAYLOAD)))
        else $error("truncated frame with free byte slots");

    // a frame taken with another waiting leaves the next one on the output
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_fire) |=> m_tvalid)
        else $error("skid frame lost");

endmodule
